// File: rtl/wcg_pkg.sv
// Window coefficient generator package: widths, fixed-point constants,
// mode and register codes and the sine result type.
// No dependencies.
package wcg_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int COEF_BITS_DEF  = 16;

    localparam int MODE_W      = 2;
    localparam int LEN_W       = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam logic [LEN_W-1:0] LEN_RESET = 17'd1024;

    localparam int PHASE_BITS = 24;
    localparam int DIV_QBITS  = PHASE_BITS + 1;
    localparam int REM_W      = LEN_W + 1;

    localparam logic [PHASE_BITS-1:0] QUARTER       = 24'h40_0000;
    localparam logic [PHASE_BITS-1:0] THREE_QUARTER = 24'hC0_0000;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [29:0] BH_A1 = 30'd524297395;
    localparam logic [29:0] BH_A2 = 30'd151698245;
    localparam logic [29:0] BH_A3 = 30'd12541305;
    // a0 + a1 - a2 + a3
    localparam logic [30:0] BH_K0 = 31'd770345334;

    localparam int TAYLOR_TERMS = 6;
    localparam logic [7:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [31:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
        32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)
    };

    // fold, angle scale, square, three stages per term, final multiply
    localparam int SIN_LAT = 3 + 3 * TAYLOR_TERMS + 1;

    typedef enum logic [MODE_W-1:0] {
        WIN_RECT   = 2'd0,
        WIN_HANN   = 2'd1,
        WIN_VORBIS = 2'd2,
        WIN_BH     = 2'd3
    } window_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_LENGTH = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic        neg;
        logic [30:0] mag;
    } sin_res_t;

endpackage

// File: rtl/wcg_intf.sv
// Channel interfaces of the window coefficient generator: sample index,
// coefficient result and configuration write. Depends on wcg_pkg.
interface wcg_sample_if #(
    parameter int INDEX_BITS = wcg_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

interface wcg_coef_if #(
    parameter int COEF_BITS = wcg_pkg::COEF_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [COEF_BITS:0] coefficient;
    logic               index_out_of_range;

    modport source (output valid, output coefficient, output index_out_of_range,
                    input ready);
    modport sink   (input valid, input coefficient, input index_out_of_range,
                    output ready);
endinterface

interface wcg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wcg_pkg::CFG_INDEX_W-1:0]   index;
    logic [wcg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/window_coefficient_generator_core.sv
// Window coefficient generator top level: config registers, phase divider,
// sine units and window combine. Depends on wcg_pkg, wcg_intf, wcg_sine.
//
// One coefficient per clock while results are taken, fully pipelined. A
// sample index passes through the restoring phase divider (one quotient bit
// per stage), a bank of three 22-stage sine units for the cosines, four
// combine stages running beside a fourth sine unit for the Vorbis window,
// and the output register. The whole pipeline holds while a result waits in
// the output register and is not taken. The user must write mode and length
// through the config channel only while no transaction is in flight; the
// block itself does not enforce this.
module window_coefficient_generator_core #(
    parameter int INDEX_BITS = wcg_pkg::INDEX_BITS_DEF,
    parameter int COEF_BITS  = wcg_pkg::COEF_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    wcg_cfg_if.sink        cfg,
    wcg_sample_if.sink     sample,
    wcg_coef_if.source     window
);
    import wcg_pkg::*;

    localparam int NUM_W     = INDEX_BITS + PHASE_BITS + 2;
    localparam int D1        = DIV_QBITS + SIN_LAT;
    localparam int B1        = D1 + 1;
    localparam int FIN       = B1 + SIN_LAT + 1;
    localparam int EARLY_DLY = SIN_LAT - 3;
    localparam int SH30      = 30 - COEF_BITS;
    localparam int SH60      = 60 - COEF_BITS;
    localparam logic [COEF_BITS:0] COEF_ONE = (COEF_BITS+1)'(1) << COEF_BITS;

    function automatic logic [COEF_BITS:0] round_q30(input logic [30:0] v);
        logic [31:0] s;
        s = (32'(v) + (32'd1 << (SH30 - 1))) >> SH30;
        return (s > 32'(COEF_ONE)) ? COEF_ONE : s[COEF_BITS:0];
    endfunction

    window_mode_t         mode_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 en;

    logic                 vld_reg [0:FIN];
    logic                 oor_reg [0:FIN];

    logic [NUM_W-1:0]     num_next;
    logic [REM_W-1:0]     den;
    logic [REM_W-1:0]     rem_reg   [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] numlo_reg [0:DIV_QBITS];
    logic [DIV_QBITS-1:0] quo_reg   [0:DIV_QBITS];

    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] t_bank [3];
    sin_res_t              s_bank [3];
    logic [31:0]           co     [3];

    logic [30:0]          h_reg;
    logic [61:0]          pr1_reg;
    logic [61:0]          pr2_reg;
    logic [61:0]          pr3_reg;
    logic [COEF_BITS:0]   hann_reg;
    logic [COEF_BITS:0]   hann3_reg;
    logic [61:0]          pos_reg;
    logic [61:0]          neg_reg;
    logic [61:0]          diff_reg;
    logic                 bh_pos_reg;
    logic [62:0]          bh_round;
    logic [COEF_BITS:0]   bh_coef;
    logic [COEF_BITS:0]   early_next;
    logic [COEF_BITS:0]   early_reg [0:EARLY_DLY];

    logic [31:0]          tv_sum;
    sin_res_t             s_vorbis;
    logic [COEF_BITS:0]   vorbis_coef;
    logic [COEF_BITS:0]   coef_next;
    logic [COEF_BITS:0]   coef_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= WIN_RECT;
            len_reg  <= LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_MODE:   mode_reg <= window_mode_t'(cfg.data[MODE_W-1:0]);
                CFG_LENGTH: len_reg  <= cfg.data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    // pipeline control
    assign en           = !vld_reg[FIN] || window.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= FIN; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= sample.valid;
            for (int j = 1; j <= FIN; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor_reg[0] <= NUM_W'(sample.sample_index) >= NUM_W'(len_reg);
            for (int j = 1; j <= FIN; j++)
            begin
                oor_reg[j] <= oor_reg[j-1];
            end
        end
    end

    // phase divider: ((2i+1) << 24 + n) / 2n, one quotient bit per stage
    assign num_next = (NUM_W'({sample.sample_index, 1'b1}) << PHASE_BITS)
                    + NUM_W'(len_reg);
    assign den      = {len_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= REM_W'(num_next >> DIV_QBITS);
            numlo_reg[0] <= num_next[DIV_QBITS-1:0];
            quo_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_QBITS; k++)
    begin : g_div
        logic [REM_W:0] tr;
        logic           ge;

        assign tr = {rem_reg[k-1], numlo_reg[k-1][DIV_QBITS-k]};
        assign ge = tr >= (REM_W+1)'(den);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]   <= ge ? REM_W'(tr - (REM_W+1)'(den)) : tr[REM_W-1:0];
                numlo_reg[k] <= numlo_reg[k-1];
                quo_reg[k]   <= {quo_reg[k-1][DIV_QBITS-2:0], ge};
            end
        end
    end

    assign phase = quo_reg[DIV_QBITS][PHASE_BITS-1:0];

    // cosine bank: Blackman-Harris takes cos of p, 2p, 3p; others take cos(p + 1/2) in unit 0, cos p in units 1 and 2
    always_comb
    begin
        if (mode_reg == WIN_BH)
        begin
            t_bank[0] = phase + QUARTER;
            t_bank[1] = {phase[PHASE_BITS-2:0], 1'b0} + QUARTER;
            t_bank[2] = phase + {phase[PHASE_BITS-2:0], 1'b0} + QUARTER;
        end
        else
        begin
            t_bank[0] = phase + THREE_QUARTER;
            t_bank[1] = phase + QUARTER;
            t_bank[2] = phase + QUARTER;
        end
    end

    for (genvar b = 0; b < 3; b++)
    begin : g_bank
        wcg_sine u_sine (
            .clk (clk),
            .en  (en),
            .t   (t_bank[b]),
            .res (s_bank[b])
        );

        assign co[b] = s_bank[b].neg ? (32'(Q30_ONE) - 32'(s_bank[b].mag))
                                     : (32'(Q30_ONE) + 32'(s_bank[b].mag));
    end

    // combine stages
    assign bh_round = (63'(diff_reg) + (63'd1 << (SH60 - 1))) >> SH60;
    assign bh_coef  = !bh_pos_reg ? '0 :
                      (bh_round > 63'(COEF_ONE)) ? COEF_ONE : bh_round[COEF_BITS:0];

    always_comb
    begin
        unique case (mode_reg)
            WIN_RECT:   early_next = COEF_ONE;
            WIN_HANN:   early_next = hann3_reg;
            WIN_BH:     early_next = bh_coef;
            WIN_VORBIS: early_next = '0;
            default:    early_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg        <= co[0][31:1];
            pr1_reg      <= 62'(BH_A1) * 62'(co[0]);
            pr2_reg      <= 62'(BH_A2) * 62'(co[1]);
            pr3_reg      <= 62'(BH_A3) * 62'(co[2]);
            hann_reg     <= round_q30(h_reg);
            pos_reg      <= (62'(BH_K0) << 30) + pr2_reg;
            neg_reg      <= pr1_reg + pr3_reg;
            hann3_reg    <= hann_reg;
            diff_reg     <= pos_reg - neg_reg;
            bh_pos_reg   <= pos_reg > neg_reg;
            early_reg[0] <= early_next;
            for (int j = 1; j <= EARLY_DLY; j++)
            begin
                early_reg[j] <= early_reg[j-1];
            end
            coef_reg     <= coef_next;
        end
    end

    // Vorbis: sine of h/4 turn
    assign tv_sum = 32'(h_reg) + 32'd128;

    wcg_sine u_sine_vorbis (
        .clk (clk),
        .en  (en),
        .t   (tv_sum[31:8]),
        .res (s_vorbis)
    );

    assign vorbis_coef = s_vorbis.neg ? '0 : round_q30(s_vorbis.mag);

    always_comb
    begin
        if (oor_reg[FIN-1])
        begin
            coef_next = '0;
        end
        else if (mode_reg == WIN_VORBIS)
        begin
            coef_next = vorbis_coef;
        end
        else
        begin
            coef_next = early_reg[EARLY_DLY];
        end
    end

    assign window.valid              = vld_reg[FIN];
    assign window.coefficient        = coef_reg;
    assign window.index_out_of_range = oor_reg[FIN];

endmodule

// File: rtl/wcg_sine.sv
// Pipelined sine of a 0.24 turn fraction: quadrant fold, Taylor series in
// Horner form, at most one multiply per stage. Depends on wcg_pkg.
module wcg_sine (
    input  logic                               clk,
    input  logic                               en,
    input  logic [wcg_pkg::PHASE_BITS-1:0]     t,
    output wcg_pkg::sin_res_t                  res
);
    import wcg_pkg::*;

    localparam int LAST_X2 = 3 * TAYLOR_TERMS;

    logic [22:0] r_next;
    logic [22:0] r_reg;
    logic        neg_reg [1:SIN_LAT];
    logic [30:0] x_reg   [2:SIN_LAT-1];
    logic [31:0] x2_reg  [3:LAST_X2];
    logic [31:0] v_reg   [TAYLOR_TERMS];
    logic [31:0] vc_reg  [TAYLOR_TERMS];
    logic [31:0] q0_reg  [TAYLOR_TERMS];
    logic [30:0] a_reg   [TAYLOR_TERMS];
    logic [53:0] prod_rx;
    logic [61:0] prod_xx;
    logic [61:0] prod_fin;
    logic [31:0] m_full;
    logic [30:0] m_next;
    logic [30:0] m_reg;

    always_comb
    begin
        r_next = t[22] ? (23'(QUARTER) - {1'b0, t[21:0]}) : {1'b0, t[21:0]};
    end

    assign prod_rx  = 54'(r_reg) * 54'(HALF_PI_Q30);
    assign prod_xx  = 62'(x_reg[2]) * 62'(x_reg[2]);
    assign prod_fin = 62'(x_reg[SIN_LAT-1]) * 62'(a_reg[TAYLOR_TERMS-1]);
    assign m_full   = prod_fin[61:30];
    assign m_next   = (m_full > 32'(Q30_ONE)) ? Q30_ONE : m_full[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg      <= r_next;
            neg_reg[1] <= t[23];
            x_reg[2]   <= prod_rx[52:22];
            x2_reg[3]  <= prod_xx[61:30];
            m_reg      <= m_next;
            for (int j = 2; j <= SIN_LAT; j++)
            begin
                neg_reg[j] <= neg_reg[j-1];
            end
            for (int j = 3; j <= SIN_LAT - 1; j++)
            begin
                x_reg[j] <= x_reg[j-1];
            end
            for (int j = 4; j <= LAST_X2; j++)
            begin
                x2_reg[j] <= x2_reg[j-1];
            end
        end
    end

    for (genvar k = 0; k < TAYLOR_TERMS; k++)
    begin : g_term
        logic [30:0] a_in;
        logic [62:0] prod_xa;
        logic [63:0] prod_rc;
        logic [39:0] prod_qd;
        logic [39:0] rem;
        logic [31:0] q;

        if (k == 0)
        begin : g_first
            assign a_in = Q30_ONE;
        end
        else
        begin : g_rest
            assign a_in = a_reg[k-1];
        end

        assign prod_xa = 63'(x2_reg[3*k+3]) * 63'(a_in);
        assign prod_rc = 64'(v_reg[k]) * 64'(TAYLOR_RECIP[k]);
        assign prod_qd = 40'(q0_reg[k]) * 40'(TAYLOR_DIV[k]);
        assign rem     = {8'd0, vc_reg[k]} - prod_qd;
        assign q       = q0_reg[k] + ((rem >= 40'(TAYLOR_DIV[k])) ? 32'd1 : 32'd0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]  <= prod_xa[61:30];
                q0_reg[k] <= prod_rc[63:32];
                vc_reg[k] <= v_reg[k];
                a_reg[k]  <= Q30_ONE - q[30:0];
            end
        end
    end

    assign res.neg = neg_reg[SIN_LAT];
    assign res.mag = m_reg;

endmodule

// File: rtl/wcg_checker.sv
// Port-level assertions for the window coefficient generator, bound to the
// top level. Depends on wcg_pkg and window_coefficient_generator_core.
module wcg_checker #(
    parameter int COEF_BITS = wcg_pkg::COEF_BITS_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COEF_BITS:0] coefficient,
    input logic               index_out_of_range
);
    import wcg_pkg::*;

    localparam logic [COEF_BITS:0] COEF_ONE = (COEF_BITS+1)'(1) << COEF_BITS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coefficient))
        else $error("result transaction dropped or changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_out_of_range |-> coefficient == '0)
        else $error("out-of-range index with nonzero coefficient");

    a_coef_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> coefficient <= COEF_ONE)
        else $error("coefficient above 1.0");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

endmodule

bind window_coefficient_generator_core wcg_checker #(
    .COEF_BITS (COEF_BITS)
) u_wcg_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ready           (sample.ready),
    .out_valid          (window.valid),
    .out_ready          (window.ready),
    .coefficient        (window.coefficient),
    .index_out_of_range (window.index_out_of_range)
);

// File: tb/tb_top.sv
// Testbench for window_coefficient_generator_core: directed table, then random
// sample indexes under random and forced back-pressure, checked against an
// integer window predictor. Depends on wcg_pkg, wcg_intf and window_coefficient_generator_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wcg_pkg::*;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned HALF_PI = 64'd1686629713;
    localparam longint unsigned BH_C0 = 64'd385204879;
    localparam longint unsigned BH_C1 = 64'd524297395;
    localparam longint unsigned BH_C2 = 64'd151698245;
    localparam longint unsigned BH_C3 = 64'd12541305;
    localparam longint unsigned TURN = 64'hFF_FFFF;
    localparam longint unsigned QTR = 64'h40_0000;
    localparam int PIPE_DRAIN = 90;
    localparam int CYCLE_LIMIT = 400000;
    localparam cfg_reg_t CFG_SPARE2 = cfg_reg_t'(2'd2);
    localparam cfg_reg_t CFG_SPARE3 = cfg_reg_t'(2'd3);

    typedef struct {
        logic [16:0] coef;
        logic        oor;
    } coef_t;

    typedef struct {
        window_mode_t mode;
        logic [16:0]  len;
        logic [15:0]  idx;
        bit           typed;
        logic [16:0]  coef;
        logic         oor;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wcg_sample_if s_if ();
    wcg_coef_if   c_if ();
    wcg_cfg_if    cfg_if ();

    window_coefficient_generator_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .sample (s_if),
        .window (c_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    window_mode_t cur_mode = WIN_RECT;
    logic [16:0]  cur_len = 17'd1024;
    coef_t        coef_q[$];
    int           errors = 0;
    int           cycles = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    int           hold_left = 0;
    bit           hold_req = 0;

    function automatic longint unsigned sin_quadrant(longint unsigned x);
        longint unsigned x2, a;
        x2 = (x * x) >> 30;
        a = ONE_Q30;
        for (int k = 0; k < 6; k++)
            a = ONE_Q30 - ((x2 * a) >> 30) / longint'(TAYLOR_DIV[k]);
        a = (x * a) >> 30;
        return (a > ONE_Q30) ? ONE_Q30 : a;
    endfunction

    function automatic longint sin_of_turn(longint unsigned t);
        longint unsigned q, r, m;
        t = t & TURN;
        q = t >> 22;
        r = t & (QTR - 1);
        if (q[0])
            r = QTR - r;
        m = sin_quadrant((r * HALF_PI) >> 22);
        return q[1] ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned cos_plus_one(longint unsigned t);
        return longint'(sin_of_turn(t + QTR)) + longint'(ONE_Q30);
    endfunction

    function automatic longint unsigned round_coef(longint unsigned v, int frac);
        longint unsigned c;
        c = (v + (64'd1 << (frac - 17))) >> (frac - 16);
        return (c > 64'd65536) ? 64'd65536 : c;
    endfunction

    function automatic coef_t window_coef(logic [15:0] idx);
        coef_t res;
        longint unsigned i, n, p, h, pos, neg;
        longint s;
        i = idx;
        n = cur_len;
        res.oor = 1'b0;
        res.coef = '0;
        if (i >= n)
        begin
            res.oor = 1'b1;
            return res;
        end
        p = ((((2 * i + 1) << 24) + n) / (2 * n)) & TURN;
        h = cos_plus_one(p + 2 * QTR) >> 1;
        case (cur_mode)
            WIN_RECT:   res.coef = 17'h10000;
            WIN_HANN:   res.coef = 17'(round_coef(h, 30));
            WIN_VORBIS:
            begin
                s = sin_of_turn((h + 128) >> 8);
                res.coef = 17'(round_coef(s < 0 ? 64'd0 : unsigned'(s), 30));
            end
            default:
            begin
                pos = (BH_C0 + BH_C1 - BH_C2 + BH_C3) * ONE_Q30
                    + BH_C2 * cos_plus_one(2 * p);
                neg = BH_C1 * cos_plus_one(p) + BH_C3 * cos_plus_one(3 * p);
                res.coef = (pos > neg) ? 17'(round_coef(pos - neg, 60)) : 17'd0;
            end
        endcase
        return res;
    endfunction

    task automatic write_reg(cfg_reg_t reg_idx, logic [16:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= reg_idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        if (reg_idx == CFG_MODE)
            cur_mode = window_mode_t'(value[1:0]);
        else if (reg_idx == CFG_LENGTH)
            cur_len = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        wait (coef_q.size() == 0);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic idle_sender();
        @(negedge clk);
        s_if.valid <= 1'b0;
    endtask

    task automatic setup(window_mode_t mode, logic [16:0] len);
        if (mode == cur_mode && len == cur_len)
            return;
        idle_sender();
        drain();
        write_reg(CFG_MODE, {15'($urandom), mode});
        write_reg(CFG_LENGTH, len);
    endtask

    // valid stays high between back-to-back transactions unless a random idle gap is drawn
    task automatic send_index(logic [15:0] idx, bit typed, coef_t typed_exp);
        @(negedge clk);
        if ($urandom_range(99) < send_idle)
        begin
            s_if.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        s_if.valid <= 1'b1;
        s_if.sample_index <= idx;
        do @(posedge clk); while (!s_if.ready);
        coef_q.push_back(typed ? typed_exp : window_coef(idx));
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            c_if.ready <= 1'b0;
        end
        else
            c_if.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        coef_t want;
        if (rst_n && c_if.valid && c_if.ready)
        begin
            if (coef_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction coef=%0d oor=%0b", $time,
                         c_if.coefficient, c_if.index_out_of_range);
            end
            else
            begin
                want = coef_q.pop_front();
                if (c_if.coefficient !== want.coef)
                begin
                    errors++;
                    $display("%0t: coefficient expected %0d actual %0d", $time,
                             want.coef, c_if.coefficient);
                end
                if (c_if.index_out_of_range !== want.oor)
                begin
                    errors++;
                    $display("%0t: index_out_of_range expected %0b actual %0b",
                             $time, want.oor, c_if.index_out_of_range);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** window_coefficient_generator_core: FAILED **");
            $finish;
        end
    end

    row_t rows[] = '{
        '{WIN_RECT,   17'd1024,   16'd0,     1, 17'd65536, 1'b0},
        '{WIN_RECT,   17'd1024,   16'd1023,  1, 17'd65536, 1'b0},
        '{WIN_RECT,   17'd1024,   16'd1024,  1, 17'd0,     1'b1},
        '{WIN_RECT,   17'd1024,   16'd65535, 1, 17'd0,     1'b1},
        '{WIN_RECT,   17'd0,      16'd0,     1, 17'd0,     1'b1},
        '{WIN_RECT,   17'd0,      16'd65535, 1, 17'd0,     1'b1},
        '{WIN_HANN,   17'd1,      16'd0,     0, 17'd0,     1'b0},
        '{WIN_HANN,   17'd65536,  16'd0,     0, 17'd0,     1'b0},
        '{WIN_HANN,   17'd65536,  16'd32767, 0, 17'd0,     1'b0},
        '{WIN_HANN,   17'd65536,  16'd65535, 0, 17'd0,     1'b0},
        '{WIN_VORBIS, 17'd65536,  16'd0,     0, 17'd0,     1'b0},
        '{WIN_VORBIS, 17'd65536,  16'd32768, 0, 17'd0,     1'b0},
        '{WIN_VORBIS, 17'd65536,  16'd65535, 0, 17'd0,     1'b0},
        '{WIN_BH,     17'd65536,  16'd0,     0, 17'd0,     1'b0},
        '{WIN_BH,     17'd65536,  16'd32768, 0, 17'd0,     1'b0},
        '{WIN_BH,     17'd65536,  16'd65535, 0, 17'd0,     1'b0},
        '{WIN_BH,     17'd2,      16'd0,     0, 17'd0,     1'b0},
        '{WIN_BH,     17'd7,      16'd3,     0, 17'd0,     1'b0},
        '{WIN_BH,     17'd1,      16'd0,     0, 17'd0,     1'b0},
        '{WIN_VORBIS, 17'd131071, 16'd65535, 0, 17'd0,     1'b0},
        '{WIN_HANN,   17'd131071, 16'd0,     0, 17'd0,     1'b0},
        '{WIN_HANN,   17'd65537,  16'd43690, 0, 17'd0,     1'b0}
    };

    initial
    begin
        coef_t typed_exp;
        logic [16:0] len;
        logic [15:0] idx;
        int sent;
        int burst;
        s_if.valid = 1'b0;
        s_if.sample_index = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_MODE;
        cfg_if.data = '0;
        c_if.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            setup(rows[r].mode, rows[r].len);
            typed_exp.coef = rows[r].coef;
            typed_exp.oor = rows[r].oor;
            send_index(rows[r].idx, rows[r].typed, typed_exp);
        end
        idle_sender();

        sent = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 26 : (ph == 1) ? 72 : 0;
            recv_idle = (ph == 0) ? 72 : (ph == 1) ? 26 : 0;
            for (int blk = 0; blk < 6; blk++)
            begin
                case ($urandom_range(9))
                    0: len = 17'd65536;
                    1: len = 17'($urandom_range(131071, 65537));
                    2: len = 17'($urandom_range(65535, 1));
                    3: len = 17'd1;
                    default: len = 17'($urandom_range(300, 1));
                endcase
                drain();
                if ($urandom_range(3) == 0)
                    write_reg($urandom_range(1) ? CFG_SPARE2 : CFG_SPARE3,
                              17'($urandom));
                write_reg(CFG_MODE, 17'($urandom));
                write_reg(CFG_LENGTH, len);
                if (ph == 2 && blk == 0)
                    hold_req = 1;
                burst = (ph == 2 && blk == 0) ? 120 : 30;
                for (int k = 0; k < burst; k++)
                begin
                    case ($urandom_range(9))
                        0: idx = 16'($urandom);
                        1: idx = (len > 17'd65536) ? 16'($urandom) : 16'(len);
                        default: idx = (len > 17'd65536) ? 16'($urandom)
                                     : 16'($urandom_range(int'(len) - 1, 0));
                    endcase
                    send_index(idx, 0, typed_exp);
                    sent++;
                end
                idle_sender();
            end
        end
        drain();
        if (errors == 0)
            $display("** window_coefficient_generator_core: PASSED **");
        else
            $display("** window_coefficient_generator_core: FAILED **");
        $finish;
    end

endmodule
